// ===== rtl/slcfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package slcfr_pkg;

   // Frame constants
   localparam logic [7:0]  SYNC_FIRST   = 8'h55;
   localparam logic [7:0]  SYNC_SECOND  = 8'hAA;
   localparam logic [15:0] SUM_SEED     = 16'hFFFF;
   localparam logic [7:0]  MODE_READ    = 8'h01;
   localparam logic [8:0]  HEADER_BYTES = 9'd6;
   localparam logic [7:0]  MIN_LENGTH   = 8'd3;

   // Input word function codes
   localparam logic FUNC_BYTE  = 1'b0;
   localparam logic FUNC_ABORT = 1'b1;

   // Frame status codes
   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_CHECKSUM = 3'd1,
      STATUS_MODE     = 3'd2,
      STATUS_OFFSET   = 3'd3,
      STATUS_SHORT    = 3'd4
   } status_type;

   // Sync hunt state
   typedef enum logic [2:0] {
      PHASE_HUNT  = 3'b001,
      PHASE_SYNC2 = 3'b010,
      PHASE_FRAME = 3'b100
   } phase_type;

endpackage

`default_nettype wire

// ===== rtl/sync_length_checksum_frame_receiver.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A result word appears on the rsp_ side in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the frame state and the result register update together.
// The input is stalled only while a result is held by rsp_stall.
// Reset (synchronous, active high): hunt for the first sync byte, running sum 0xFFFF,
// expected offset 0, result register empty.
module sync_length_checksum_frame_receiver (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_write_enable,
   input  wire logic [7:0]  csr_write_data,
   // input bytes
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_func,
   input  wire logic [7:0]  req_rx_byte,
   // results
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_payload_valid,
   output logic [7:0]       rsp_payload_byte,
   output logic [7:0]       rsp_payload_index,
   output logic             rsp_frame_done,
   output logic [2:0]       rsp_frame_status,
   output logic [7:0]       rsp_payload_length
);
   import slcfr_pkg::*;

   logic [7:0]  expected_offset_ff;
   phase_type   phase_ff, phase_in;
   logic [8:0]  position_ff, position_in;
   logic [7:0]  length_ff, length_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  mode_ff, mode_in;
   logic [7:0]  offset_ff, offset_in;
   logic [7:0]  check_low_ff, check_low_in;

   logic        rsp_valid_ff;
   logic        pv_ff, pv_in;
   logic [7:0]  pb_ff, pb_in;
   logic [7:0]  pi_ff, pi_in;
   logic        fd_ff, fd_in;
   status_type  fs_ff, fs_in;
   logic [7:0]  pl_ff, pl_in;

   logic        accept;
   logic [8:0]  check_pos;
   logic [15:0] sum_minus_byte;
   logic [8:0]  index_wide;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign check_pos      = {1'b0, length_ff} + 9'd4;
   assign sum_minus_byte = sum_ff - {8'd0, req_rx_byte};
   assign index_wide     = position_ff - HEADER_BYTES;

   // Frame state machine and result word
   always_comb begin
      phase_in     = phase_ff;
      position_in  = position_ff;
      length_in    = length_ff;
      sum_in       = sum_ff;
      mode_in      = mode_ff;
      offset_in    = offset_ff;
      check_low_in = check_low_ff;
      pv_in        = 1'b0;
      pb_in        = 8'd0;
      pi_in        = 8'd0;
      fd_in        = 1'b0;
      fs_in        = STATUS_OK;
      pl_in        = 8'd0;

      if (req_func == FUNC_ABORT) begin
         phase_in    = PHASE_HUNT;
         position_in = 9'd0;
      end else begin
         unique case (phase_ff)
            PHASE_SYNC2: begin
               if (req_rx_byte == SYNC_SECOND) begin
                  phase_in    = PHASE_FRAME;
                  position_in = 9'd2;
               end else begin
                  phase_in    = PHASE_HUNT;
                  position_in = 9'd0;
               end
            end
            PHASE_FRAME: begin
               if (position_ff == 9'd2) begin
                  // length byte
                  if (req_rx_byte < MIN_LENGTH) begin
                     fd_in       = 1'b1;
                     fs_in       = STATUS_SHORT;
                     phase_in    = PHASE_HUNT;
                     position_in = 9'd0;
                  end else begin
                     length_in   = req_rx_byte;
                     sum_in      = SUM_SEED - {8'd0, req_rx_byte};
                     position_in = 9'd3;
                  end
               end else if (position_ff < HEADER_BYTES || position_ff < check_pos) begin
                  // command, mode, offset and payload bytes
                  if (position_ff == 9'd4) begin
                     mode_in = req_rx_byte;
                  end else if (position_ff == 9'd5) begin
                     offset_in = req_rx_byte;
                  end else if (position_ff >= HEADER_BYTES) begin
                     pv_in = 1'b1;
                     pb_in = req_rx_byte;
                     pi_in = index_wide[7:0];
                  end
                  sum_in      = sum_minus_byte;
                  position_in = position_ff + 9'd1;
               end else if (position_ff == check_pos) begin
                  check_low_in = req_rx_byte;
                  position_in  = position_ff + 9'd1;
               end else begin
                  // checksum high byte ends the frame
                  fd_in = 1'b1;
                  pl_in = length_ff - 8'd2;
                  if (check_low_ff != sum_ff[7:0] || req_rx_byte != sum_ff[15:8]) begin
                     fs_in = STATUS_CHECKSUM;
                  end else if (mode_ff != MODE_READ) begin
                     fs_in = STATUS_MODE;
                  end else if (offset_ff != expected_offset_ff) begin
                     fs_in = STATUS_OFFSET;
                  end else begin
                     fs_in = STATUS_OK;
                  end
                  phase_in    = PHASE_HUNT;
                  position_in = 9'd0;
               end
            end
            default: begin
               if (req_rx_byte == SYNC_FIRST) begin
                  phase_in    = PHASE_SYNC2;
                  position_in = 9'd1;
               end else begin
                  phase_in    = PHASE_HUNT;
                  position_in = 9'd0;
               end
            end
         endcase
      end
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_offset_ff <= 8'd0;
      end else if (csr_write_enable) begin
         expected_offset_ff <= csr_write_data;
      end
   end

   // Frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_HUNT;
         position_ff  <= 9'd0;
         length_ff    <= 8'd0;
         sum_ff       <= SUM_SEED;
         mode_ff      <= 8'd0;
         offset_ff    <= 8'd0;
         check_low_ff <= 8'd0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         position_ff  <= position_in;
         length_ff    <= length_in;
         sum_ff       <= sum_in;
         mode_ff      <= mode_in;
         offset_ff    <= offset_in;
         check_low_ff <= check_low_in;
      end
   end

   // Result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register payload
   always_ff @(posedge clock) begin
      if (accept) begin
         pv_ff <= pv_in;
         pb_ff <= pb_in;
         pi_ff <= pi_in;
         fd_ff <= fd_in;
         fs_ff <= fs_in;
         pl_ff <= pl_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload_valid  = pv_ff;
   assign rsp_payload_byte   = pb_ff;
   assign rsp_payload_index  = pi_ff;
   assign rsp_frame_done     = fd_ff;
   assign rsp_frame_status   = fs_ff;
   assign rsp_payload_length = pl_ff;

endmodule

`default_nettype wire

// ===== rtl/slcfr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module slcfr_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_payload_valid,
   input wire logic [7:0] rsp_payload_byte,
   input wire logic [7:0] rsp_payload_index,
   input wire logic       rsp_frame_done,
   input wire logic [2:0] rsp_frame_status,
   input wire logic [7:0] rsp_payload_length
);
   import slcfr_pkg::*;

   // Result register is empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A word is never both a payload byte and the end of a frame
   a_payload_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload_valid && rsp_frame_done))
      else $error("payload byte flagged as frame end");

   // A non-ok status only comes with the end of a frame
   a_status_with_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_status != STATUS_OK) |-> rsp_frame_done)
      else $error("status without frame end");

   // A short-length frame reports zero payload length, payload byte and payload index
   a_short_no_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_status == STATUS_SHORT) |->
      (rsp_payload_length == 8'd0 && rsp_payload_byte == 8'd0 &&
       rsp_payload_index == 8'd0))
      else $error("short frame carries data");

   // A stalled result word holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
      (rsp_valid && $stable(rsp_payload_byte) && $stable(rsp_frame_status)))
      else $error("stalled result changed");

endmodule

bind sync_length_checksum_frame_receiver slcfr_checker u_slcfr_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_payload_valid  (rsp_payload_valid),
   .rsp_payload_byte   (rsp_payload_byte),
   .rsp_payload_index  (rsp_payload_index),
   .rsp_frame_done     (rsp_frame_done),
   .rsp_frame_status   (rsp_frame_status),
   .rsp_payload_length (rsp_payload_length)
);

`default_nettype wire
